// File: src/strided_dma_beat_generator_top_macros.svh
// assertion macros shared by the strided dma beat generator modules
`ifndef STRIDED_DMA_BEAT_GENERATOR_TOP_MACROS_SVH
`define STRIDED_DMA_BEAT_GENERATOR_TOP_MACROS_SVH

`ifndef SYNTHESIS

// check that a property holds on every clock outside reset
`define SDBG_ASSERT(name, c, r, prop) \
  name: assert property (@(posedge c) disable iff (r) (prop)) \
    else $error("sdbg assertion failed");

// check that a condition implies a consequence in the same cycle
`define SDBG_ASSERT_IMPLY(name, c, r, ante, cons) \
  name: assert property (@(posedge c) disable iff (r) (ante) |-> (cons)) \
    else $error("sdbg implication failed");

// check that a condition implies a consequence in the next cycle
`define SDBG_ASSERT_NEXT(name, c, r, ante, cons) \
  name: assert property (@(posedge c) disable iff (r) (ante) |=> (cons)) \
    else $error("sdbg next-cycle implication failed");

`else

`define SDBG_ASSERT(name, c, r, prop)
`define SDBG_ASSERT_IMPLY(name, c, r, ante, cons)
`define SDBG_ASSERT_NEXT(name, c, r, ante, cons)

`endif

`endif

// File: src/sdbg_pkg.sv
// types and constants of the strided dma beat generator
`default_nettype none

package sdbg_pkg;

  // local memory bank size and beat size in bytes
  localparam int unsigned BANK_BYTES = 4096;
  localparam int unsigned BEAT_BYTES = 8;

  // local address layout
  localparam logic [12:0] LOCAL_BANK_BIT   = 13'(BANK_BYTES);
  localparam logic [12:0] LOCAL_OFF_MASK   = 13'(BANK_BYTES - 1);
  localparam logic [12:0] LOCAL_ALIGN_MASK = 13'((2 * BANK_BYTES - 1) & 32'h1FF8);

  // length readback pattern after a finished transfer
  localparam logic [23:0] LEN_DONE_LOW = 24'h000FF8;

  // input opcodes
  localparam logic [2:0] OP_TICK       = 3'd0;
  localparam logic [2:0] OP_SET_LOCAL  = 3'd1;
  localparam logic [2:0] OP_SET_MAIN   = 3'd2;
  localparam logic [2:0] OP_START_LOC  = 3'd3;
  localparam logic [2:0] OP_START_MAIN = 3'd4;

  // command kinds passed from front to back
  localparam logic [2:0] CMD_NOP       = 3'd0;
  localparam logic [2:0] CMD_TICK      = 3'd1;
  localparam logic [2:0] CMD_SET_LOCAL = 3'd2;
  localparam logic [2:0] CMD_SET_MAIN  = 3'd3;
  localparam logic [2:0] CMD_START     = 3'd4;

  // decoded command
  typedef struct packed {
    logic [2:0]  kind;
    logic        to_main;
    logic [31:0] word;
    logic [12:0] local_addr;
    logic [28:0] main_addr;
    logic [9:0]  beats_per_row;
    logic [7:0]  rows;
    logic [11:0] skip;
  } cmd_t;

endpackage

`default_nettype wire

// File: src/sdbg_front.sv
// front end: accepts items and decodes them into commands
`default_nettype none

module sdbg_front (
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [31:0]  s_axis_tdata,   // write_data
  input  wire logic [2:0]   s_axis_tuser,   // opcode
  input  wire logic         q_full,
  output logic              q_push,
  output sdbg_pkg::cmd_t    q_cmd
);
  import sdbg_pkg::*;

  // accept while the queue has room
  assign s_axis_tready = !q_full;
  assign q_push        = s_axis_tvalid && !q_full;

  // classify the opcode and pre-extract the register fields
  always_comb begin
    q_cmd               = '0;
    q_cmd.word          = s_axis_tdata;
    q_cmd.local_addr    = s_axis_tdata[12:0] & LOCAL_ALIGN_MASK;
    q_cmd.main_addr     = {s_axis_tdata[28:3], 3'b000};
    q_cmd.beats_per_row = 10'(s_axis_tdata[11:3]) + 10'd1;
    q_cmd.rows          = s_axis_tdata[19:12];
    q_cmd.skip          = {s_axis_tdata[31:23], 3'b000};
    q_cmd.to_main       = (s_axis_tuser == OP_START_MAIN);
    case (s_axis_tuser)
      OP_TICK:       q_cmd.kind = CMD_TICK;
      OP_SET_LOCAL:  q_cmd.kind = CMD_SET_LOCAL;
      OP_SET_MAIN:   q_cmd.kind = CMD_SET_MAIN;
      OP_START_LOC:  q_cmd.kind = CMD_START;
      OP_START_MAIN: q_cmd.kind = CMD_START;
      default:       q_cmd.kind = CMD_NOP;
    endcase
  end

endmodule

`default_nettype wire

// File: src/sdbg_queue.sv
// command queue between front and back
`default_nettype none

`include "strided_dma_beat_generator_top_macros.svh"

module sdbg_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  sdbg_pkg::cmd_t  push_cmd,
  output logic            full,
  input  wire logic       pop,
  output logic            not_empty,
  output sdbg_pkg::cmd_t  head_cmd
);
  import sdbg_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  cmd_t            mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full      = (count == CntW'(DEPTH));
  assign not_empty = (count != '0);
  assign head_cmd  = mem[rd_ptr];

  // storage write
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `SDBG_ASSERT(a_count_bound, clk, rst, count <= CntW'(DEPTH))
  `SDBG_ASSERT(a_no_push_full, clk, rst, !(push && full))
  `SDBG_ASSERT(a_no_pop_empty, clk, rst, !(pop && !not_empty))

endmodule

`default_nettype wire

// File: src/sdbg_back.sv
// back end: transfer state, beat address generation and result register
`default_nettype none

`include "strided_dma_beat_generator_top_macros.svh"

module sdbg_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_wr_en,
  input  wire logic [23:0]   cfg_wr_data,
  input  wire logic          q_not_empty,
  input  sdbg_pkg::cmd_t     q_cmd,
  output logic               q_pop,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // beat_local_addr, beat_main_addr, busy_res, range_error, local_addr_readback,
  // main_addr_readback, length_readback, 2 zero bits
  output logic [119:0]       m_axis_tdata,
  output logic [1:0]         m_axis_tuser,  // beat_valid, beat_to_main
  output logic               m_axis_tlast   // beat_last
);
  import sdbg_pkg::*;

  // configuration and transfer state
  logic [23:0] main_memory_bytes;
  logic [12:0] pending_local_addr, pending_local_addr_next;
  logic [28:0] pending_main_addr, pending_main_addr_next;
  logic [12:0] cur_local_addr, cur_local_addr_next;
  logic [28:0] cur_main_addr, cur_main_addr_next;
  logic [31:0] length_word, length_word_next;
  logic [9:0]  beats_per_row, beats_per_row_next;
  logic [9:0]  beats_left_in_row, beats_left_in_row_next;
  logic [7:0]  rows_left, rows_left_next;
  logic [11:0] row_skip, row_skip_next;
  logic        active, active_next;
  logic        to_main, to_main_next;

  // per-item result values
  logic        bv, bdir, blast, rerr;
  logic [12:0] bloc;
  logic [28:0] bmain;
  logic [9:0]  left_dec;
  logic [12:0] local_step;
  logic [28:0] main_step;

  // executor takes a command whenever the result register is free
  assign q_pop = q_not_empty && (!m_axis_tvalid || m_axis_tready);

  assign left_dec   = beats_left_in_row - 10'd1;
  assign local_step = (cur_local_addr & LOCAL_BANK_BIT)
                    | (((cur_local_addr & LOCAL_OFF_MASK) + 13'(BEAT_BYTES))
                       & LOCAL_OFF_MASK);
  assign main_step  = cur_main_addr + 29'(BEAT_BYTES);

  // next state and result for the command at the queue head
  always_comb begin
    pending_local_addr_next = pending_local_addr;
    pending_main_addr_next  = pending_main_addr;
    cur_local_addr_next     = cur_local_addr;
    cur_main_addr_next      = cur_main_addr;
    length_word_next        = length_word;
    beats_per_row_next      = beats_per_row;
    beats_left_in_row_next  = beats_left_in_row;
    rows_left_next          = rows_left;
    row_skip_next           = row_skip;
    active_next             = active;
    to_main_next            = to_main;
    bv    = 1'b0;
    bdir  = 1'b0;
    bloc  = '0;
    bmain = '0;
    blast = 1'b0;
    rerr  = 1'b0;
    case (q_cmd.kind)
      CMD_SET_LOCAL: begin
        pending_local_addr_next = q_cmd.local_addr;
      end
      CMD_SET_MAIN: begin
        pending_main_addr_next = q_cmd.main_addr;
      end
      CMD_START: begin
        if (!active) begin
          length_word_next = q_cmd.word;
          if (pending_main_addr > {5'b0, main_memory_bytes}) begin
            rerr = 1'b1;
          end else begin
            cur_local_addr_next    = pending_local_addr;
            cur_main_addr_next     = pending_main_addr;
            beats_per_row_next     = q_cmd.beats_per_row;
            beats_left_in_row_next = q_cmd.beats_per_row;
            rows_left_next         = q_cmd.rows;
            row_skip_next          = q_cmd.skip;
            to_main_next           = q_cmd.to_main;
            active_next            = 1'b1;
          end
        end
      end
      CMD_TICK: begin
        if (active) begin
          bv    = 1'b1;
          bdir  = to_main;
          bloc  = cur_local_addr;
          bmain = cur_main_addr;
          cur_local_addr_next    = local_step;
          cur_main_addr_next     = main_step;
          beats_left_in_row_next = left_dec;
          if (left_dec == '0) begin
            if (rows_left != '0) begin
              rows_left_next         = rows_left - 8'd1;
              beats_left_in_row_next = beats_per_row;
              cur_main_addr_next     = main_step + 29'(row_skip);
            end else begin
              blast            = 1'b1;
              active_next      = 1'b0;
              length_word_next = {length_word[31:24], LEN_DONE_LOW};
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      main_memory_bytes <= 24'd8388608;
    end else if (cfg_wr_en) begin
      main_memory_bytes <= cfg_wr_data;
    end
  end

  // transfer state update
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_local_addr <= '0;
      pending_main_addr  <= '0;
      cur_local_addr     <= '0;
      cur_main_addr      <= '0;
      length_word        <= '0;
      beats_per_row      <= '0;
      beats_left_in_row  <= '0;
      rows_left          <= '0;
      row_skip           <= '0;
      active             <= 1'b0;
      to_main            <= 1'b0;
    end else if (q_pop) begin
      pending_local_addr <= pending_local_addr_next;
      pending_main_addr  <= pending_main_addr_next;
      cur_local_addr     <= cur_local_addr_next;
      cur_main_addr      <= cur_main_addr_next;
      length_word        <= length_word_next;
      beats_per_row      <= beats_per_row_next;
      beats_left_in_row  <= beats_left_in_row_next;
      rows_left          <= rows_left_next;
      row_skip           <= row_skip_next;
      active             <= active_next;
      to_main            <= to_main_next;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (q_pop) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      m_axis_tdata <= {2'b00, length_word_next, cur_main_addr_next, cur_local_addr_next,
                       rerr, active_next, bmain, bloc};
      m_axis_tuser <= {bdir, bv};
      m_axis_tlast <= blast;
    end
  end

  `SDBG_ASSERT_NEXT(a_pop_gives_result, clk, rst, q_pop, m_axis_tvalid)
  `SDBG_ASSERT_IMPLY(a_active_row_left, clk, rst, active,
                     beats_left_in_row != '0 && beats_per_row != '0)
  `SDBG_ASSERT_IMPLY(a_end_marks_last, clk, rst, !$past(rst) && $fell(active),
                     m_axis_tvalid && m_axis_tlast && m_axis_tuser[0])
  `SDBG_ASSERT_IMPLY(a_refusal_no_beat, clk, rst, m_axis_tvalid && m_axis_tdata[43],
                     !m_axis_tuser[0] && !m_axis_tlast)

endmodule

`default_nettype wire

// File: src/strided_dma_beat_generator_top.sv
// Strided two-dimensional DMA beat generator. Each input item (opcode in tuser,
// register word in tdata) gives exactly one result item: address writes load
// the pending local and main addresses, start opcodes while idle launch a
// transfer of count+1 rows of length/8+1 beats, and each tick during a transfer
// issues one 8-byte beat address pair; each result carries busy, refusal flag
// and register readbacks. The block takes one item per clock while the output
// is not stalled: items are decoded into a command queue of QUEUE_DEPTH entries,
// and the executor retires one command per cycle into a result register, so an
// item's result is registered in the queue and then in the result register
// before it reaches the output. The executor's state update sets that rate; a
// stalled output backs up through the queue to s_axis_tready.
`default_nettype none

module strided_dma_beat_generator_top #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_wr_en,
  input  wire logic [23:0]   cfg_wr_data,   // main_memory_bytes
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [31:0]   s_axis_tdata,  // write_data
  input  wire logic [2:0]    s_axis_tuser,  // opcode
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // beat_local_addr, beat_main_addr, busy_res, range_error, local_addr_readback,
  // main_addr_readback, length_readback, 2 zero bits
  output logic [119:0]       m_axis_tdata,
  output logic [1:0]         m_axis_tuser,  // beat_valid, beat_to_main
  output logic               m_axis_tlast   // beat_last
);
  import sdbg_pkg::*;

  logic q_push, q_full, q_pop, q_not_empty;
  cmd_t push_cmd, head_cmd;

  // decode
  sdbg_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (push_cmd)
  );

  // command queue
  sdbg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_cmd  (head_cmd)
  );

  // execute
  sdbg_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .q_not_empty   (q_not_empty),
    .q_cmd         (head_cmd),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

// File: test/strided_dma_beat_generator_top_tb.sv
// self-checking testbench for the strided dma beat generator: predicts every result item and compares
module strided_dma_beat_generator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sdbg_pkg::*;

  // opcodes the block ignores
  localparam logic [2:0] OP_RSVD5 = 3'd5;
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 300;
  localparam int PHASE_ITEMS = 240;

  typedef struct {
    bit [2:0]  op;
    bit [31:0] wd;
  } dma_cmd_t;

  typedef struct {
    bit        beat_valid;
    bit        beat_to_main;
    bit [12:0] beat_local_addr;
    bit [28:0] beat_main_addr;
    bit        beat_last;
    bit        busy;
    bit        range_error;
    bit [12:0] local_rb;
    bit [28:0] main_rb;
    bit [31:0] length_rb;
  } dma_result_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          cfg_wr_en = 1'b0;
  logic [23:0]   cfg_wr_data = '0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [31:0]   s_axis_tdata = '0;   // write_data
  logic [2:0]    s_axis_tuser = '0;   // opcode
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  // beat_local_addr, beat_main_addr, busy_res, range_error, local_addr_readback,
  // main_addr_readback, length_readback, 2 zero bits
  logic [119:0]  m_axis_tdata;
  logic [1:0]    m_axis_tuser;        // beat_valid, beat_to_main
  logic          m_axis_tlast;        // beat_last

  strided_dma_beat_generator_top uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // shadow copy of the engine state
  bit [23:0] mem_limit = 24'd8388608;
  bit [12:0] nxt_loc, loc_ptr;
  bit [28:0] nxt_main, main_ptr;
  bit [31:0] len_reg;
  bit [9:0]  row_beats, beats_togo;
  bit [7:0]  rows_togo;
  bit [11:0] skip_bytes;
  bit        xfer_on, xfer_dir;

  dma_cmd_t    cmd_backlog[$];
  dma_result_t results_due[$];

  int errors = 0;
  int cycle_count = 0;
  int tx_gap_max = 3;
  int rx_gap_max = 3;
  int tx_gap = 0;
  int rx_wait = 0;
  int hold_left = 0;
  int hold_req = 0;
  int hold_done = 0;

  // clock
  initial begin
    forever #1 clk = ~clk;
  end

  // advance the shadow engine by one item and return the result it gives
  function automatic dma_result_t dma_advance(bit [2:0] op, bit [31:0] wd);
    dma_result_t r;
    r = '{default: '0};
    if (op == OP_SET_LOCAL) begin
      nxt_loc = wd[12:0] & LOCAL_ALIGN_MASK;
    end else if (op == OP_SET_MAIN) begin
      nxt_main = {wd[28:3], 3'b000};
    end else if ((op == OP_START_LOC || op == OP_START_MAIN) && !xfer_on) begin
      len_reg = wd;
      if (nxt_main > 29'(mem_limit)) begin
        r.range_error = 1'b1;
      end else begin
        loc_ptr    = nxt_loc;
        main_ptr   = nxt_main;
        row_beats  = 10'(wd[11:3]) + 10'd1;
        beats_togo = row_beats;
        rows_togo  = wd[19:12];
        skip_bytes = {wd[31:23], 3'b000};
        xfer_dir   = (op == OP_START_MAIN);
        xfer_on    = 1'b1;
      end
    end else if (op == OP_TICK && xfer_on) begin
      r.beat_valid      = 1'b1;
      r.beat_to_main    = xfer_dir;
      r.beat_local_addr = loc_ptr;
      r.beat_main_addr  = main_ptr;
      // offset wraps inside the bank, bank bit kept
      loc_ptr    = (loc_ptr & LOCAL_BANK_BIT) | ((loc_ptr + 13'(BEAT_BYTES)) & LOCAL_OFF_MASK);
      main_ptr   = main_ptr + 29'(BEAT_BYTES);
      beats_togo = beats_togo - 10'd1;
      if (beats_togo == 10'd0) begin
        if (rows_togo != 8'd0) begin
          rows_togo  = rows_togo - 8'd1;
          beats_togo = row_beats;
          main_ptr   = main_ptr + 29'(skip_bytes);
        end else begin
          r.beat_last = 1'b1;
          xfer_on     = 1'b0;
          len_reg     = {len_reg[31:24], LEN_DONE_LOW};
        end
      end
    end
    r.busy      = xfer_on;
    r.local_rb  = loc_ptr;
    r.main_rb   = main_ptr;
    r.length_rb = len_reg;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  task automatic queue_cmd(bit [2:0] op, bit [31:0] wd);
    dma_cmd_t c;
    c.op = op;
    c.wd = wd;
    cmd_backlog.push_back(c);
  endtask

  // one random item of any opcode but tick
  task automatic queue_noise(inout int n);
    bit [2:0] op;
    op = 3'($urandom_range(OP_SET_LOCAL, OP_RSVD7));
    queue_cmd(op, $urandom());
    if (op <= OP_START_MAIN) n++;
  endtask

  // address setup, start and enough ticks to finish the transfer
  task automatic queue_transfer(inout int n);
    bit [31:0] word, mainw;
    int beats, shape;
    if ($urandom_range(0, 3) != 0) begin
      queue_cmd(OP_SET_LOCAL, $urandom());
      n++;
    end
    case ($urandom_range(0, 9))
      0: mainw = $urandom();
      1: mainw = {3'($urandom()), 29'(mem_limit) + 29'd8};
      2: mainw = {3'($urandom()), 29'(mem_limit)};
      default: mainw = {3'($urandom()), 29'($urandom_range(0, mem_limit))};
    endcase
    if ($urandom_range(0, 4) != 0) begin
      queue_cmd(OP_SET_MAIN, mainw);
      n++;
    end
    // mostly short transfers, now and then a long row or many short rows
    shape = $urandom_range(0, 39);
    word = $urandom();
    if (shape == 0) begin
      word[19:12] = 8'd0;
    end else if (shape == 1) begin
      word[11:0]  = 12'($urandom_range(0, 7));
      word[19:12] = 8'($urandom_range(0, 255));
    end else begin
      word[11:0]  = 12'($urandom_range(0, 47));
      word[19:12] = 8'($urandom_range(0, 3));
    end
    queue_cmd($urandom_range(0, 1) ? OP_START_MAIN : OP_START_LOC, word);
    n++;
    beats = (int'(word[11:3]) + 1) * (int'(word[19:12]) + 1) + $urandom_range(0, 2);
    for (int k = 0; k < beats; k++) begin
      if ($urandom_range(0, 31) == 0) queue_noise(n);
      queue_cmd(OP_TICK, $urandom());
      n++;
    end
  endtask

  // sampled away from the active edge so driver and monitor updates have settled
  task automatic wait_drained();
    while (cmd_backlog.size() != 0 || s_axis_tvalid || results_due.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mem_limit(bit [23:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    mem_limit = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_phase(int tx_max, int rx_max, bit long_hold);
    int n;
    n = 0;
    tx_gap_max = tx_max;
    rx_gap_max = rx_max;
    while (n < PHASE_ITEMS) begin
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 3)) queue_noise(n);
      end
      queue_transfer(n);
    end
    // receiver stalls for a long hold at the start of the phase
    if (long_hold) hold_req++;
    wait_drained();
  endtask

  // stimulus sequence
  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part
    queue_cmd(OP_TICK, 32'hFFFF_FFFF);        // tick while idle
    queue_cmd(OP_RSVD5, 32'h0000_0000);
    queue_cmd(OP_RSVD6, 32'hFFFF_FFFF);
    queue_cmd(OP_RSVD7, 32'h5555_AAAA);
    queue_cmd(OP_SET_LOCAL, 32'hFFFF_FFFF);   // top of bank one, wraps on the next beat
    queue_cmd(OP_SET_MAIN, 32'h0080_0000);    // exactly the memory size
    queue_cmd(OP_START_MAIN, 32'hFFF0_1008);  // two rows of two beats, largest skip
    queue_cmd(OP_TICK, 32'h0000_0000);
    queue_cmd(OP_START_LOC, 32'h0000_0000);   // start while active is ignored
    queue_cmd(OP_SET_LOCAL, 32'h0000_0007);   // only used by the next start
    queue_cmd(OP_TICK, 32'h0000_0000);
    queue_cmd(OP_TICK, 32'h0000_0000);
    queue_cmd(OP_TICK, 32'h0000_0000);        // last beat
    queue_cmd(OP_TICK, 32'h0000_0000);
    queue_cmd(OP_SET_MAIN, 32'h0080_0008);    // one beat past memory size
    queue_cmd(OP_START_LOC, 32'h1234_5678);   // refused
    queue_cmd(OP_SET_MAIN, 32'hFFFF_FFFF);
    queue_cmd(OP_START_MAIN, 32'h0000_0000);  // refused
    queue_cmd(OP_SET_MAIN, 32'h0000_0000);
    queue_cmd(OP_START_LOC, 32'h0000_0000);   // single beat
    queue_cmd(OP_TICK, 32'hFFFF_FFFF);
    queue_cmd(OP_SET_LOCAL, 32'h0000_0FF0);   // wrap inside bank zero
    queue_cmd(OP_START_LOC, 32'h0010_0010);
    repeat (6) queue_cmd(OP_TICK, 32'h0000_0000);
    wait_drained();

    // random phases over several memory sizes
    run_phase(6, 6, 1'b0);
    write_mem_limit(24'd0);
    run_phase(0, 6, 1'b1);
    write_mem_limit(24'hFF_FFFF);
    run_phase(6, 0, 1'b0);
    write_mem_limit(24'($urandom_range(0, 8388608)));
    run_phase(0, 0, 1'b0);
    write_mem_limit(24'd4096);
    run_phase(3, 3, 1'b1);
    write_mem_limit(24'd8388608);
    run_phase(6, 6, 1'b0);

    repeat (16) @(posedge clk);
    if (results_due.size() != 0) begin
      $error("%0d expected result items never arrived", results_due.size());
      errors++;
    end
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // input driver: predicts each accepted item, then offers the next after a random gap
  always @(posedge clk) begin : driver
    dma_cmd_t c;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      tx_gap <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        results_due.push_back(dma_advance(s_axis_tuser, s_axis_tdata));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (cmd_backlog.size() != 0) begin
          c = cmd_backlog.pop_front();
          s_axis_tuser  <= c.op;
          s_axis_tdata  <= c.wd;
          s_axis_tvalid <= 1'b1;
          tx_gap <= $urandom_range(0, tx_gap_max);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // output monitor: checks each accepted result item and paces tready
  always @(posedge clk) begin : monitor
    dma_result_t want;
    int w;
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_wait <= 0;
    end else begin
      w = rx_wait;
      if (m_axis_tvalid && m_axis_tready) begin
        if (results_due.size() == 0) begin
          $error("result item with no expectation waiting");
          errors++;
        end else begin
          want = results_due.pop_front();
          check_field("beat_valid", 32'(want.beat_valid), 32'(m_axis_tuser[0]));
          check_field("beat_to_main", 32'(want.beat_to_main), 32'(m_axis_tuser[1]));
          check_field("beat_local_addr", 32'(want.beat_local_addr),
                      32'(m_axis_tdata[12:0]));
          check_field("beat_main_addr", 32'(want.beat_main_addr),
                      32'(m_axis_tdata[41:13]));
          check_field("beat_last", 32'(want.beat_last), 32'(m_axis_tlast));
          check_field("busy_res", 32'(want.busy), 32'(m_axis_tdata[42]));
          check_field("range_error", 32'(want.range_error), 32'(m_axis_tdata[43]));
          check_field("local_addr_readback", 32'(want.local_rb),
                      32'(m_axis_tdata[56:44]));
          check_field("main_addr_readback", 32'(want.main_rb),
                      32'(m_axis_tdata[85:57]));
          check_field("length_readback", want.length_rb, m_axis_tdata[117:86]);
        end
        w = $urandom_range(0, rx_gap_max);
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_axis_tready <= 1'b0;
        rx_wait <= w;
      end else if (hold_req != hold_done) begin
        hold_done <= hold_done + 1;
        hold_left <= LONG_HOLD;
        m_axis_tready <= 1'b0;
        rx_wait <= w;
      end else if (w > 0) begin
        rx_wait <= w - 1;
        m_axis_tready <= 1'b0;
      end else begin
        rx_wait <= 0;
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule
